/* rtl/d10snd_pkg.sv */
// Package for the D10 AES3 sound element packer.
// Holds the sizes, codes and struct types shared by every rtl file; depends on nothing.
package d10snd_pkg;

    localparam int MAX_SAMPLES  = 1920;
    localparam int NUM_CHANNELS = 8;

    localparam int CHAN_W     = 3;
    localparam int CHAN_SLOTS = 1 << CHAN_W;
    localparam int COUNT_W    = 11;
    localparam int INDEX_W    = 14;
    localparam int WORD_W     = 32;
    localparam int SAMPLE_W   = 24;
    localparam int MASK_W     = 8;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 3;

    localparam logic [MASK_W-1:0] CHAN_LIMIT = MASK_W'((1 << NUM_CHANNELS) - 1);

    localparam int CNT_25HZ_RAW = 1920;
    localparam int CNT_EVEN_RAW = 1602;
    localparam int CNT_ODD_RAW  = 1601;

    localparam logic [COUNT_W-1:0] CNT_25HZ =
        COUNT_W'((CNT_25HZ_RAW > MAX_SAMPLES) ? MAX_SAMPLES : CNT_25HZ_RAW);
    localparam logic [COUNT_W-1:0] CNT_EVEN =
        COUNT_W'((CNT_EVEN_RAW > MAX_SAMPLES) ? MAX_SAMPLES : CNT_EVEN_RAW);
    localparam logic [COUNT_W-1:0] CNT_ODD =
        COUNT_W'((CNT_ODD_RAW > MAX_SAMPLES) ? MAX_SAMPLES : CNT_ODD_RAW);

    localparam logic [PHASE_W-1:0] SEQ_LEN  = 3'd5;
    localparam logic [PHASE_W-1:0] SEQ_LAST = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE_IDX    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_IDX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTE_IDX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVALID_IDX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_IDX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_IDX  = 3'd5;

    typedef enum logic {
        MODE_SAMPLE = 1'b0,
        MODE_CLOSE  = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_DROPPED    = 2'd1,
        ST_UNREG      = 2'd2,
        ST_INCOMPLETE = 2'd3
    } status_t;

    typedef struct packed {
        logic                rate_is_25hz;
        logic                width_is_24bit;
        logic [MASK_W-1:0]   mute_mask;
        logic [MASK_W-1:0]   invalid_mask;
        logic [MASK_W-1:0]   registered_mask;
        logic [PHASE_W-1:0]  sequence_offset;
    } cfg_t;

    typedef struct packed {
        mode_t               mode;
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic [INDEX_W-1:0]  word_index;
        logic [WORD_W-1:0]   word_value;
        logic                write_word;
        logic                package_done;
        status_t             status;
    } result_t;

endpackage

/* rtl/d10_aes3_sound_element_packer.sv */
// Top level of the D10 AES3 sound element packer: input register, packing, output register.
// Depends on d10snd_pkg, d10snd_cfg and d10snd_pack.
//
//  channel | direction | tdata                               | tuser                      | tlast
//  --------+-----------+-------------------------------------+----------------------------+------
//  s_axis  | in        | channel[2:0], sample[26:3]          | mode[0]                    | -
//  m_axis  | out       | word_index[13:0], word_value[45:14] | write_word[0], status[2:1] | done
//  cfg     | in        | cfg_we, cfg_index, cfg_data         | -                          | -
//
// One transaction per cycle while m_axis is not stalled; items pass input, then output register.
// The counter update and word packing for an item happen as it moves from the input
// register to the output register. Reset clears counters, phase and configuration.
// An output stall holds the result; a new transaction is still taken while the input
// register is free or drains in the same cycle.
module d10_aes3_sound_element_packer
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [d10snd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // channel, sample
    input  logic                                 s_axis_tuser,  // mode
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [d10snd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // word_index, word_value
    output logic [d10snd_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,  // write_word, status
    output logic                                 m_axis_tlast,  // package_done
    input  logic                                 cfg_we,
    input  logic [d10snd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [d10snd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import d10snd_pkg::*;

    cfg_t    cfg;
    result_t res;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    logic    advance;
    logic    in_fire;

    d10snd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    d10snd_pack u_pack
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_item_reg.mode    <= mode_t'(s_axis_tuser);
            in_item_reg.channel <= s_axis_tdata[CHAN_W-1:0];
            in_item_reg.sample  <= s_axis_tdata[CHAN_W+SAMPLE_W-1:CHAN_W];
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b0, out_res_reg.word_value, out_res_reg.word_index};
    assign m_axis_tuser  = {out_res_reg.status, out_res_reg.write_word};
    assign m_axis_tlast  = out_res_reg.package_done;

    a_done_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_res_reg.package_done) |-> out_res_reg.write_word)
        else $error("header transaction without write_word");

    a_drop_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_res_reg.status == ST_DROPPED)) |-> !out_res_reg.write_word)
        else $error("dropped sample marked for write");

    a_sample_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_res_reg.write_word && !out_res_reg.package_done)
        |-> (out_res_reg.word_index != '0))
        else $error("sample word placed on header index");

    a_input_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("held item not moved to output register");

endmodule

/* rtl/d10snd_cfg.sv */
// Configuration register bank of the D10 AES3 sound element packer.
// Depends on d10snd_pkg for the register indexes and the cfg_t struct.
module d10snd_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [d10snd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [d10snd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output d10snd_pkg::cfg_t                   cfg
);
    import d10snd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate_is_25hz    <= 1'b1;
            cfg_reg.width_is_24bit  <= 1'b1;
            cfg_reg.mute_mask       <= '0;
            cfg_reg.invalid_mask    <= '0;
            cfg_reg.registered_mask <= '0;
            cfg_reg.sequence_offset <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RATE_IDX:    cfg_reg.rate_is_25hz    <= cfg_data[0];
                CFG_WIDTH_IDX:   cfg_reg.width_is_24bit  <= cfg_data[0];
                CFG_MUTE_IDX:    cfg_reg.mute_mask       <= cfg_data[MASK_W-1:0];
                CFG_INVALID_IDX: cfg_reg.invalid_mask    <= cfg_data[MASK_W-1:0];
                CFG_REG_IDX:     cfg_reg.registered_mask <= cfg_data[MASK_W-1:0];
                CFG_OFFSET_IDX:  cfg_reg.sequence_offset <= cfg_data[PHASE_W-1:0];
                default:         cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/d10snd_pack.sv */
// Per-channel sample counters, five-frame phase and word packing logic.
// Depends on d10snd_pkg; result is combinational from the held item and state.
module d10snd_pack
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  d10snd_pkg::item_t    item,
    input  d10snd_pkg::cfg_t     cfg,
    output d10snd_pkg::result_t  res
);
    import d10snd_pkg::*;

    logic [COUNT_W-1:0] count_reg [CHAN_SLOTS];
    logic [PHASE_W-1:0] phase_reg;

    logic [PHASE_W-1:0] off_mod;
    logic [PHASE_W:0]   phase_sum;
    logic [PHASE_W:0]   seq_raw;
    logic [PHASE_W-1:0] seq_idx;
    logic [COUNT_W-1:0] pkg_count;
    logic [MASK_W-1:0]  valid_byte;
    logic [MASK_W-1:0]  mismatch;
    logic [COUNT_W-1:0] pos;
    logic [WORD_W-1:0]  audio_word;
    logic               incomplete;
    logic [PHASE_W-1:0] phase_next;

    always_comb
    begin
        off_mod    = (cfg.sequence_offset >= SEQ_LEN) ? cfg.sequence_offset - SEQ_LEN
                                                      : cfg.sequence_offset;
        phase_sum  = {1'b0, phase_reg} + {1'b0, off_mod};
        seq_raw    = (phase_sum >= {1'b0, SEQ_LEN}) ? phase_sum - {1'b0, SEQ_LEN} : phase_sum;
        seq_idx    = cfg.rate_is_25hz ? '0 : seq_raw[PHASE_W-1:0];
        pkg_count  = cfg.rate_is_25hz ? CNT_25HZ : (seq_idx[0] ? CNT_ODD : CNT_EVEN);
        valid_byte = (cfg.mute_mask | cfg.registered_mask) & ~cfg.invalid_mask & CHAN_LIMIT;
        pos        = count_reg[item.channel];
        audio_word = cfg.width_is_24bit ? {4'b0, item.sample, 4'b0}
                                        : {4'b0, item.sample[15:0], 12'b0};
        phase_next = (phase_reg == SEQ_LAST) ? '0 : phase_reg + 3'd1;
        for (int i = 0; i < CHAN_SLOTS; i++)
        begin
            mismatch[i] = (count_reg[i] != pkg_count);
        end
        incomplete = |(cfg.registered_mask & CHAN_LIMIT & mismatch);
    end

    always_comb
    begin
        res.word_index   = '0;
        res.word_value   = '0;
        res.write_word   = 1'b0;
        res.package_done = 1'b0;
        res.status       = ST_OK;
        if (item.mode == MODE_CLOSE)
        begin
            res.word_value   = {valid_byte, 5'b0, pkg_count, 5'b0, seq_idx};
            res.write_word   = 1'b1;
            res.package_done = 1'b1;
            res.status       = incomplete ? ST_INCOMPLETE : ST_OK;
        end
        else if (!CHAN_LIMIT[item.channel])
        begin
            res.status = ST_UNREG;
        end
        else if (pos >= pkg_count)
        begin
            res.status = ST_DROPPED;
        end
        else
        begin
            res.word_index = {pos, item.channel} + INDEX_W'(1);
            res.write_word = 1'b1;
            if (!cfg.registered_mask[item.channel])
            begin
                res.word_value = WORD_W'(item.channel);
                res.status     = ST_UNREG;
            end
            else if (valid_byte[item.channel] && !cfg.mute_mask[item.channel])
            begin
                res.word_value = audio_word | WORD_W'(item.channel);
            end
            else
            begin
                res.word_value = WORD_W'(item.channel);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHAN_SLOTS; i++)
            begin
                count_reg[i] <= '0;
            end
            phase_reg <= '0;
        end
        else if (fire)
        begin
            if (item.mode == MODE_CLOSE)
            begin
                for (int i = 0; i < CHAN_SLOTS; i++)
                begin
                    count_reg[i] <= '0;
                end
                phase_reg <= phase_next;
            end
            else if (CHAN_LIMIT[item.channel] && (pos < pkg_count))
            begin
                count_reg[item.channel] <= pos + COUNT_W'(1);
            end
        end
    end

endmodule
